[src/hsoc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsoc_pkg
// Shared widths and codes of the hash set with overflow chains.
// ----------------------------------------------------------------------------
package hsoc_pkg;

  // key width and status width
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;

  // request modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // slot flags
  localparam logic [1:0] FLAG_EMPTY   = 2'd0;
  localparam logic [1:0] FLAG_USED    = 2'd1;
  localparam logic [1:0] FLAG_DELETED = 2'd2;

  // response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

endpackage

[src/hsoc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsoc_req_if / hsoc_rsp_if
// Valid/ready channels for requests and responses of the hash set.
// ----------------------------------------------------------------------------
interface hsoc_req_if import hsoc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [KEY_W-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

interface hsoc_rsp_if import hsoc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

[src/hash_set_with_overflow_chains.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_set_with_overflow_chains
// Hash set of 31-bit keys with a home area and a chained overflow area.
// ----------------------------------------------------------------------------
// One request (insert or remove) is worked at a time; each gives one status
// response. The slot store is a single-port-read, single-port-write memory of
// 2*HOME_SLOTS entries with a registered read. A request passes the hash,
// home and finish states; an insert that finds its home slot taken walks the
// overflow links one read at a time and, at the chain end, appends a slot
// from the free list in the alloc and link states. With HOME_SLOTS a power
// of two the home index is a mask of the key; otherwise it comes from a
// reciprocal multiplication unit. After reset a clearing pass initializes
// flags and free-list links; no request is taken until it ends. A response
// waits in an output register, so the next request is taken while it is
// still pending.
// ----------------------------------------------------------------------------
module hash_set_with_overflow_chains import hsoc_pkg::*; #(
  parameter int HOME_SLOTS = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  hsoc_req_if.sink   req_i,
  hsoc_rsp_if.source rsp_o
);

  localparam int TOTAL = 2 * HOME_SLOTS;
  localparam int HW    = $clog2(HOME_SLOTS);
  localparam int AW    = $clog2(TOTAL);
  localparam int LW    = $clog2(TOTAL + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(TOTAL);

  // controller states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_HOME  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_ALLOC = 3'd5;
  localparam logic [2:0] S_LINK  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [LW-1:0]    free_head_q, free_head_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic             mode_q;
  logic [KEY_W-1:0] key_q;
  status_e          res_q, res_d;
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;

  // slot memory
  logic [KEY_W-1:0] mem_key  [TOTAL];
  logic [1:0]       mem_flag [TOTAL];
  logic [LW-1:0]    mem_next [TOTAL];

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_key;
  logic [1:0]       wr_flag;
  logic [LW-1:0]    wr_next;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_key_q;
  logic [1:0]       rd_flag_q;
  logic [LW-1:0]    rd_next_q;

  logic             accept;
  logic             home_done;
  logic [HW-1:0]    home_idx;
  logic             hit;
  logic             more;

  assign accept     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_status_q;

  // home index unit
  hsoc_home #(
    .HOME_SLOTS (HOME_SLOTS)
  ) u_home (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .key_i   (req_i.key),
    .done_o  (home_done),
    .home_o  (home_idx)
  );

  // match and chain continuation on the entry just read
  assign hit  = (rd_flag_q == FLAG_USED) && (rd_key_q == key_q);
  assign more = (rd_next_q < NULL_LINK);

  // controller; accesses are sequenced so no read meets a write to its entry
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    free_head_d  = free_head_q;
    pos_d        = pos_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    wr_en        = 1'b0;
    wr_addr      = pos_q;
    wr_key       = rd_key_q;
    wr_flag      = rd_flag_q;
    wr_next      = rd_next_q;
    rd_en        = 1'b0;
    rd_addr      = pos_q;

    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_key  = '0;
        wr_flag = FLAG_EMPTY;
        if (clr_q < AW'(HOME_SLOTS) || clr_q == AW'(TOTAL - 1)) begin
          wr_next = NULL_LINK;
        end else begin
          wr_next = LW'(clr_q) + LW'(1);
        end
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(TOTAL - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (home_done) begin
          rd_en   = 1'b1;
          rd_addr = {1'b0, home_idx};
          pos_d   = {1'b0, home_idx};
          state_d = S_HOME;
        end
      end
      S_HOME: begin
        state_d = S_FIN;
        if (mode_q == MODE_REMOVE) begin
          if (hit) begin
            wr_en   = 1'b1;
            wr_flag = FLAG_DELETED;
            res_d   = ST_DONE;
          end else begin
            res_d = ST_MISSING;
          end
        end else if (hit) begin
          res_d = ST_DUP;
        end else if (rd_flag_q != FLAG_USED) begin
          wr_en   = 1'b1;
          wr_key  = key_q;
          wr_flag = FLAG_USED;
          res_d   = ST_DONE;
        end else if (more) begin
          rd_en   = 1'b1;
          rd_addr = rd_next_q[AW-1:0];
          pos_d   = rd_next_q[AW-1:0];
          state_d = S_WALK;
        end else begin
          state_d = S_ALLOC;
        end
      end
      S_WALK: begin
        if (hit) begin
          res_d   = ST_DUP;
          state_d = S_FIN;
        end else if (more) begin
          rd_en   = 1'b1;
          rd_addr = rd_next_q[AW-1:0];
          pos_d   = rd_next_q[AW-1:0];
        end else begin
          state_d = S_ALLOC;
        end
      end
      S_ALLOC: begin
        // link the chain tail to the free head and fetch its successor
        if (free_head_q == NULL_LINK) begin
          res_d   = ST_FULL;
          state_d = S_FIN;
        end else begin
          wr_en   = 1'b1;
          wr_next = free_head_q;
          rd_en   = 1'b1;
          rd_addr = free_head_q[AW-1:0];
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        // fill the fresh slot and pop it off the free list
        wr_en       = 1'b1;
        wr_addr     = free_head_q[AW-1:0];
        wr_key      = key_q;
        wr_flag     = FLAG_USED;
        wr_next     = NULL_LINK;
        free_head_d = rd_next_q;
        res_d       = ST_DONE;
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_key[wr_addr]  <= wr_key;
      mem_flag[wr_addr] <= wr_flag;
      mem_next[wr_addr] <= wr_next;
    end
    if (rd_en) begin
      rd_key_q  <= mem_key[rd_addr];
      rd_flag_q <= mem_flag[rd_addr];
      rd_next_q <= mem_next[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      free_head_q <= LW'(HOME_SLOTS);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_head_q <= free_head_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= req_i.mode;
      key_q  <= req_i.key;
    end
    pos_q        <= pos_d;
    res_q        <= res_d;
    out_status_q <= out_status_d;
  end

endmodule

[src/hsoc_home.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsoc_home
// Home slot index unit: key modulo HOME_SLOTS, a mask for a power of two,
// otherwise a multiplication by a rounded-up reciprocal.
// ----------------------------------------------------------------------------
module hsoc_home import hsoc_pkg::*; #(
  parameter int HOME_SLOTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [KEY_W-1:0]              key_i,
  output logic                          done_o,
  output logic [$clog2(HOME_SLOTS)-1:0] home_o
);

  localparam int HW = $clog2(HOME_SLOTS);

  logic          done_q, done_d;
  logic [HW-1:0] rem_q, rem_d;

  assign done_o = done_q;
  assign home_o = rem_q;

  generate
    if ((HOME_SLOTS & (HOME_SLOTS - 1)) == 0) begin : g_pow2
      // low key bits are the remainder
      always_comb begin
        done_d = start_i;
        rem_d  = start_i ? key_i[HW-1:0] : rem_q;
      end
    end else begin : g_recip
      // quotient as key times a rounded-up reciprocal, exact for 31-bit keys;
      // remainder is key minus quotient times HOME_SLOTS
      localparam int              SH    = KEY_W + HW;
      localparam longint unsigned RCP_L =
        ((64'd1 << SH) + 64'(HOME_SLOTS) - 64'd1) / 64'(HOME_SLOTS);
      localparam logic [KEY_W:0]  RCP   = (KEY_W+1)'(RCP_L);
      localparam int              PW    = 2 * KEY_W + 1;

      logic [2:0]       stg_q, stg_d;
      logic [KEY_W-1:0] key_q, key_d;
      logic [PW-1:0]    prod_q, prod_d;
      logic [KEY_W-1:0] quo;
      logic [KEY_W-1:0] qm_q, qm_d;
      logic [KEY_W-1:0] diff;

      // product, quotient times divisor, then difference, each step ending in a register
      always_comb begin
        stg_d  = {stg_q[1:0], start_i};
        key_d  = start_i ? key_i : key_q;
        prod_d = PW'(key_q) * PW'(RCP);
        quo    = KEY_W'(prod_q >> SH);
        qm_d   = quo * KEY_W'(HOME_SLOTS);
        diff   = key_q - qm_q;
        done_d = stg_q[2];
        rem_d  = stg_q[2] ? diff[HW-1:0] : rem_q;
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          stg_q <= '0;
        end else begin
          stg_q <= stg_d;
        end
      end

      always_ff @(posedge clk_i) begin
        key_q  <= key_d;
        prod_q <= prod_d;
        qm_q   <= qm_d;
      end
    end
  endgenerate

  // done pulse and remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

endmodule

[src/hsoc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsoc_checker
// Port-level checks of the hash set: transaction balance and response hold.
// ----------------------------------------------------------------------------
module hsoc_checker import hsoc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] rsp_status_i
);

  logic [2:0] pend_q;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  // requests accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(req_fire) - 3'(rsp_fire);
    end
  end

  // no response without a pending request
  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 3'd0)
    else $error("response without pending request");

  // at most one request in work and one response waiting
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd2)
    else $error("too many transactions in flight");

  // no request taken while one is in work and a response waits
  a_no_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 3'd2) |-> !req_ready_i)
    else $error("request taken with two transactions in flight");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i))
    else $error("stalled response changed");

endmodule

bind hash_set_with_overflow_chains hsoc_checker u_hsoc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status)
);
